// ----- hdl/bcss_pkg.sv -----
`timescale 1ns / 1ps

package bcss_pkg;

    localparam int CFG_W     = 24;
    localparam int CFG_IDX_W = 3;

    localparam int FRAME_BITS_DEF = 11;
    localparam int LEAD_ZEROS_DEF = 2;
    localparam int TIME_WIDTH_DEF = 24;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_STARTUP    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SHORT_GAP  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_GAP   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLDOFF    = 3'd4;

    localparam logic [CFG_W-1:0] STARTUP_RST    = 24'd3500000;
    localparam logic [CFG_W-1:0] LONG_PRESS_RST = 24'd800000;
    localparam logic [CFG_W-1:0] SHORT_GAP_RST  = 24'd4000;
    localparam logic [CFG_W-1:0] LONG_GAP_RST   = 24'd500000;
    localparam logic [CFG_W-1:0] HOLDOFF_RST    = 24'd2000000;

    localparam logic [7:0] CMD_INIT = 8'h84;
    localparam logic [7:0] CMD_SYNC = 8'h04;

    // sequence step codes: 0..4 walk the long-press sequence
    localparam logic [2:0] STEP_FIRST    = 3'd0;
    localparam logic [2:0] STEP_LONG_GAP = 3'd2;
    localparam logic [2:0] STEP_LAST     = 3'd4;
    localparam logic [2:0] STEP_SYNC     = 3'd5;
    localparam logic [2:0] STEP_INIT     = 3'd6;

    typedef enum logic [2:0] {
        PH_STARTUP,
        PH_IDLE,
        PH_PRESS,
        PH_SEND,
        PH_GAP,
        PH_HOLDOFF
    } t_phase;

    typedef struct packed {
        logic       data_level;
        logic       sending;
        logic [7:0] command_byte;
    } t_result;

    function automatic logic [7:0] seq_cmd(input logic [2:0] step);
        logic [7:0] cmd;
        case (step)
            3'd0:    cmd = 8'hA9;
            3'd1:    cmd = 8'hB6;
            3'd2:    cmd = 8'h09;
            3'd3:    cmd = 8'hA0;
            default: cmd = 8'hB0;
        endcase
        return cmd;
    endfunction

endpackage

// ----- hdl/button_command_serial_sender_top.sv -----
`timescale 1ns / 1ps

// Sends command bytes on a data line clocked by the partner, driven by one
// sample tick per transfer (partner clock level and active-low button).
// After reset it waits startup_ticks and sends the init command; a short
// press sends the sync command, a long press the five-command sequence
// with gaps, both followed by a hold-off. Each frame is FRAME_BITS bits:
// LEAD_ZEROS zeros, then the command MSB first, then zeros; bit i changes
// on partner clock transition 2i and the line returns high after
// transition 2*FRAME_BITS-1. One tick is taken every clock cycle unless
// stalled; its result is registered in an output register with a one-entry
// skid stage, so the input stalls only when both are full. The user writes
// configuration through the write port only while idle; the block has no check.
module button_command_serial_sender_top #(
    parameter int FRAME_BITS = bcss_pkg::FRAME_BITS_DEF,
    parameter int LEAD_ZEROS = bcss_pkg::LEAD_ZEROS_DEF,
    parameter int TIME_WIDTH = bcss_pkg::TIME_WIDTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [bcss_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [bcss_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic                           i_clock_level,
    input  logic                           i_button_level,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic                           o_data_level,
    output logic                           o_sending,
    output logic [7:0]                     o_command_byte
);
    import bcss_pkg::*;

    localparam int LW = (TIME_WIDTH > CFG_W) ? TIME_WIDTH : CFG_W;
    localparam logic [LW-1:0] TMAX_EXT = LW'({TIME_WIDTH{1'b1}});
    localparam logic [4:0] TC_END = 5'(2 * FRAME_BITS - 1);
    localparam logic [3:0] LEAD_IDX = 4'(LEAD_ZEROS);

    // configuration registers
    logic [CFG_W-1:0] r_startup, r_long_press, r_short_gap, r_long_gap, r_holdoff;

    // sender state
    t_phase                r_phase, n_phase;
    logic [TIME_WIDTH-1:0] r_cnt, n_cnt;
    logic [2:0]            r_step, n_step;
    logic [4:0]            r_tc, n_tc;
    logic [7:0]            r_shift, n_shift;
    logic                  r_prev_clk, n_prev_clk;
    logic                  r_data, n_data;
    logic [7:0]            r_last_cmd, n_last_cmd;

    // result registers
    t_result r_out, r_skid;
    logic    r_out_valid, r_skid_valid;
    t_result n_result;

    logic in_accept, out_take;

    assign o_in_stall  = r_skid_valid;
    assign in_accept   = i_in_valid && !r_skid_valid;
    assign out_take    = r_out_valid && !i_out_stall;

    assign o_out_valid    = r_out_valid;
    assign o_data_level   = r_out.data_level;
    assign o_sending      = r_out.sending;
    assign o_command_byte = r_out.command_byte;

    function automatic logic [TIME_WIDTH-1:0] clamp(input logic [CFG_W-1:0] lim);
        logic [LW-1:0] ext;
        ext = LW'(lim);
        if (ext > TMAX_EXT) begin
            ext = TMAX_EXT;
        end
        return TIME_WIDTH'(ext);
    endfunction

    function automatic logic [TIME_WIDTH-1:0] sat_inc(input logic [TIME_WIDTH-1:0] c);
        return (c == {TIME_WIDTH{1'b1}}) ? c : c + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_startup    <= STARTUP_RST;
            r_long_press <= LONG_PRESS_RST;
            r_short_gap  <= SHORT_GAP_RST;
            r_long_gap   <= LONG_GAP_RST;
            r_holdoff    <= HOLDOFF_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_STARTUP:    r_startup    <= i_cfg_data;
                CFG_LONG_PRESS: r_long_press <= i_cfg_data;
                CFG_SHORT_GAP:  r_short_gap  <= i_cfg_data;
                CFG_LONG_GAP:   r_long_gap   <= i_cfg_data;
                CFG_HOLDOFF:    r_holdoff    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        logic       start;
        logic [7:0] start_cmd;
        logic [2:0] start_step;
        logic [2:0] nxt;
        logic [4:0] tc_inc;
        logic       drive;
        logic [3:0] drive_idx;

        n_phase    = r_phase;
        n_cnt      = r_cnt;
        n_step     = r_step;
        n_tc       = r_tc;
        n_shift    = r_shift;
        n_prev_clk = r_prev_clk;
        n_data     = r_data;
        n_last_cmd = r_last_cmd;

        start      = 1'b0;
        start_cmd  = CMD_INIT;
        start_step = STEP_INIT;
        nxt        = STEP_FIRST;
        tc_inc     = r_tc + 5'd1;
        drive      = 1'b0;
        drive_idx  = '0;

        case (r_phase)
            PH_STARTUP: begin
                if (r_cnt >= clamp(r_startup)) begin
                    start = 1'b1;
                end else begin
                    n_cnt = sat_inc(r_cnt);
                end
            end
            PH_IDLE: begin
                if (!i_button_level) begin
                    n_phase = PH_PRESS;
                    n_cnt   = '0;
                end
            end
            PH_PRESS: begin
                if (i_button_level) begin
                    start      = 1'b1;
                    start_cmd  = CMD_SYNC;
                    start_step = STEP_SYNC;
                end else begin
                    n_cnt = sat_inc(r_cnt);
                    if (n_cnt >= clamp(r_long_press)) begin
                        start      = 1'b1;
                        start_cmd  = seq_cmd(STEP_FIRST);
                        start_step = STEP_FIRST;
                    end
                end
            end
            PH_SEND: begin
                if (i_clock_level != r_prev_clk) begin
                    n_prev_clk = i_clock_level;
                    n_tc       = tc_inc;
                    if (tc_inc >= TC_END) begin
                        // frame done: release the line and pick the follow-up
                        n_data = 1'b1;
                        n_cnt  = '0;
                        if (r_step == STEP_INIT) begin
                            n_phase = PH_IDLE;
                        end else if (r_step < STEP_LAST) begin
                            n_phase = PH_GAP;
                        end else begin
                            n_phase = PH_HOLDOFF;
                        end
                    end else if (!tc_inc[0]) begin
                        drive     = 1'b1;
                        drive_idx = tc_inc[4:1];
                    end
                end
            end
            PH_GAP: begin
                if (r_cnt >= clamp((r_step == STEP_LONG_GAP) ? r_long_gap : r_short_gap))
                begin
                    nxt        = (r_step >= STEP_LAST) ? STEP_LAST : r_step + 3'd1;
                    start      = 1'b1;
                    start_cmd  = seq_cmd(nxt);
                    start_step = nxt;
                end else begin
                    n_cnt = sat_inc(r_cnt);
                end
            end
            PH_HOLDOFF: begin
                if (r_cnt >= clamp(r_holdoff)) begin
                    n_phase = PH_IDLE;
                end else begin
                    n_cnt = sat_inc(r_cnt);
                end
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase

        if (start) begin
            n_shift    = start_cmd;
            n_last_cmd = start_cmd;
            n_step     = start_step;
            n_tc       = '0;
            n_prev_clk = i_clock_level;
            n_phase    = PH_SEND;
            drive      = 1'b1;
            drive_idx  = '0;
        end

        // put one frame bit on the line: lead zeros, then shift out MSB first
        if (drive) begin
            if (drive_idx < LEAD_IDX) begin
                n_data = 1'b0;
            end else begin
                n_data  = n_shift[7];
                n_shift = {n_shift[6:0], 1'b0};
            end
        end

        n_result.data_level   = n_data;
        n_result.sending      = (n_phase == PH_SEND);
        n_result.command_byte = n_last_cmd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_STARTUP;
            r_cnt      <= '0;
            r_step     <= '0;
            r_tc       <= '0;
            r_shift    <= '0;
            r_prev_clk <= 1'b0;
            r_data     <= 1'b1;
            r_last_cmd <= '0;
        end else if (in_accept) begin
            r_phase    <= n_phase;
            r_cnt      <= n_cnt;
            r_step     <= n_step;
            r_tc       <= n_tc;
            r_shift    <= n_shift;
            r_prev_clk <= n_prev_clk;
            r_data     <= n_data;
            r_last_cmd <= n_last_cmd;
        end
    end

    // output register with a skid stage behind it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || out_take) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= in_accept;
            end
        end else if (in_accept) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || out_take) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (in_accept) begin
                r_out <= n_result;
            end
        end else if (in_accept) begin
            r_skid <= n_result;
        end
    end

`ifndef SYNTHESIS
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid stage holds a transfer while the output register is empty");

    a_skid_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_take && r_skid_valid) |=> (r_out_valid && !r_skid_valid))
        else $error("skid transfer not moved to the output register");

    a_line_idle_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase != PH_SEND) |-> r_data)
        else $error("data line low outside a frame");

    a_frame_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_SEND) |-> (r_tc < TC_END))
        else $error("transition count past end of frame");
`endif

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 1ps

module tb;
    import bcss_pkg::*;

    localparam int          CYCLE_LIMIT = 500000;
    localparam int          LAST_EDGE   = 2 * FRAME_BITS_DEF - 1;
    localparam logic [CFG_W-1:0] TICK_MAX = {CFG_W{1'b1}};
    localparam logic [7:0]  LONG_SEQ [0:4] = '{8'hA9, 8'hB6, 8'h09, 8'hA0, 8'hB0};

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_W-1:0]     i_cfg_data = '0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_stall;
    logic                 i_clock_level = 1'b0;
    logic                 i_button_level = 1'b1;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    logic                 o_data_level;
    logic                 o_sending;
    logic [7:0]           o_command_byte;

    button_command_serial_sender_top dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_clock_level  (i_clock_level),
        .i_button_level (i_button_level),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_data_level   (o_data_level),
        .o_sending      (o_sending),
        .o_command_byte (o_command_byte)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // sender model state and its copy of the registers
    t_phase           m_phase = PH_STARTUP;
    logic [CFG_W-1:0] m_ticks = '0;
    logic [2:0]       m_step = '0;
    logic [4:0]       m_edges = '0;
    logic [7:0]       m_shift = '0;
    logic             m_prev_clk = 1'b0;
    logic             m_data = 1'b1;
    logic [7:0]       m_cmd = '0;
    logic [CFG_W-1:0] r_startup = STARTUP_RST;
    logic [CFG_W-1:0] r_long_press = LONG_PRESS_RST;
    logic [CFG_W-1:0] r_short_gap = SHORT_GAP_RST;
    logic [CFG_W-1:0] r_long_gap = LONG_GAP_RST;
    logic [CFG_W-1:0] r_holdoff = HOLDOFF_RST;

    t_result          line_q[$];
    int               err_cnt = 0;
    int unsigned      cycle_cnt = 0;

    // stimulus generators
    logic             gen_clk = 1'b0;
    int               gen_clk_left = 0;
    int               clk_half_max = 2;
    bit               clk_noise = 1'b0;
    logic             gen_btn = 1'b1;
    int               gen_btn_left = 5;
    int               burst_left = 0;
    bit               gaps_on = 1'b0;

    // receiver stall pattern
    bit               hold_req = 1'b0;
    int               hold_left = 0;
    logic [31:0]      stall_pat = '0;
    logic [4:0]       stall_pos = '0;

    function automatic bit tick_wait_over(input logic [CFG_W-1:0] limit);
        if (m_ticks >= limit)
            return 1'b1;
        if (m_ticks != TICK_MAX)
            m_ticks = m_ticks + 1'b1;
        return 1'b0;
    endfunction

    function automatic void shift_bit_out(input logic [3:0] idx);
        if (idx < LEAD_ZEROS_DEF) begin
            m_data = 1'b0;
        end else begin
            m_data  = m_shift[7];
            m_shift = {m_shift[6:0], 1'b0};
        end
    endfunction

    function automatic void open_frame(input logic [7:0] cmd, input logic [2:0] step,
                                       input logic clk);
        m_shift    = cmd;
        m_cmd      = cmd;
        m_step     = step;
        m_edges    = '0;
        m_prev_clk = clk;
        m_phase    = PH_SEND;
        shift_bit_out(4'd0);
    endfunction

    function automatic void close_frame();
        m_data  = 1'b1;
        m_ticks = '0;
        if (m_step == STEP_INIT)
            m_phase = PH_IDLE;
        else if (m_step < STEP_LAST)
            m_phase = PH_GAP;
        else
            m_phase = PH_HOLDOFF;
    endfunction

    // advance the sender by one sample tick and queue the line levels it leaves
    function automatic void predict_line(input logic clk, input logic btn);
        logic [2:0] nxt;
        t_result    res;
        case (m_phase)
            PH_STARTUP: begin
                if (tick_wait_over(r_startup))
                    open_frame(CMD_INIT, STEP_INIT, clk);
            end
            PH_IDLE: begin
                if (!btn) begin
                    m_phase = PH_PRESS;
                    m_ticks = '0;
                end
            end
            PH_PRESS: begin
                if (btn) begin
                    open_frame(CMD_SYNC, STEP_SYNC, clk);
                end else begin
                    if (m_ticks != TICK_MAX)
                        m_ticks = m_ticks + 1'b1;
                    if (m_ticks >= r_long_press)
                        open_frame(LONG_SEQ[STEP_FIRST], STEP_FIRST, clk);
                end
            end
            PH_SEND: begin
                if (clk != m_prev_clk) begin
                    m_prev_clk = clk;
                    m_edges    = m_edges + 5'd1;
                    if (m_edges >= LAST_EDGE)
                        close_frame();
                    else if (!m_edges[0])
                        shift_bit_out(m_edges[4:1]);
                end
            end
            PH_GAP: begin
                if (tick_wait_over(m_step == STEP_LONG_GAP ? r_long_gap : r_short_gap)) begin
                    nxt = m_step + 3'd1;
                    if (nxt > STEP_LAST)
                        nxt = STEP_LAST;
                    open_frame(LONG_SEQ[nxt], nxt, clk);
                end
            end
            PH_HOLDOFF: begin
                if (tick_wait_over(r_holdoff))
                    m_phase = PH_IDLE;
            end
            default: m_phase = PH_IDLE;
        endcase
        res.data_level   = m_data;
        res.sending      = (m_phase == PH_SEND);
        res.command_byte = m_cmd;
        line_q.push_back(res);
    endfunction

    function automatic logic next_partner_clock();
        if (clk_noise) begin
            gen_clk = 1'($urandom_range(0, 1));
        end else if (gen_clk_left == 0) begin
            gen_clk      = ~gen_clk;
            gen_clk_left = $urandom_range(0, clk_half_max - 1);
        end else begin
            gen_clk_left--;
        end
        return gen_clk;
    endfunction

    function automatic logic next_button();
        if (gen_btn_left == 0) begin
            gen_btn = ~gen_btn;
            if (gen_btn)
                gen_btn_left = $urandom_range(0, 30);
            else if ($urandom_range(0, 7) == 0)
                gen_btn_left = 0;
            else
                gen_btn_left = $urandom_range(0, int'(r_long_press) + 6);
        end else begin
            gen_btn_left--;
        end
        return gen_btn;
    endfunction

    // offer one tick; valid is left high after the transfer
    task automatic send_tick(input logic clk_lvl, input logic btn_lvl);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = gaps_on ? $urandom_range(0, 6) : 0;
            if (gap != 0) begin
                @(negedge i_clk);
                i_in_valid <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
        burst_left--;
        @(negedge i_clk);
        i_in_valid     <= 1'b1;
        i_clock_level  <= clk_lvl;
        i_button_level <= btn_lvl;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        predict_line(clk_lvl, btn_lvl);
    endtask

    task automatic send_toggled(input int n, input logic btn_lvl);
        repeat (n) begin
            gen_clk = ~gen_clk;
            send_tick(gen_clk, btn_lvl);
        end
    endtask

    // stop offering and hold until every transfer has come back
    task automatic drain_line();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (line_q.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        case (idx)
            CFG_STARTUP:    r_startup = val;
            CFG_LONG_PRESS: r_long_press = val;
            CFG_SHORT_GAP:  r_short_gap = val;
            CFG_LONG_GAP:   r_long_gap = val;
            CFG_HOLDOFF:    r_holdoff = val;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic test_power_on_init();
        gaps_on = 1'b0;
        // button is ignored during the start-up wait
        send_toggled(2, 1'b1);
        send_toggled(2, 1'b0);
        drain_line();
        write_reg(CFG_STARTUP, '0);
        send_toggled(24, 1'b1);
    endtask

    task automatic test_short_press_sync();
        drain_line();
        write_reg(CFG_LONG_PRESS, 24'd4);
        write_reg(CFG_HOLDOFF, 24'd3);
        send_toggled(1, 1'b1);
        send_toggled(3, 1'b0);
        send_toggled(6, 1'b1);
        // press while the frame goes out
        send_toggled(4, 1'b0);
        send_toggled(20, 1'b1);
    endtask

    task automatic test_long_press_sequence();
        logic [CFG_W-1:0] lp;
        for (int run = 0; run < 2; run++) begin
            lp = (run == 0) ? 24'd0 : 24'd3;
            drain_line();
            write_reg(CFG_LONG_PRESS, lp);
            write_reg(CFG_SHORT_GAP, run == 0 ? 24'd0 : 24'd2);
            write_reg(CFG_LONG_GAP, run == 0 ? 24'd3 : 24'd0);
            write_reg(CFG_HOLDOFF, '0);
            gaps_on = (run == 1);
            send_toggled(1, 1'b1);
            // press exactly as long as the threshold
            send_toggled((lp == 0) ? 2 : int'(lp) + 1, 1'b0);
            while (m_phase != PH_IDLE)
                send_toggled(1, 1'b1);
        end
    endtask

    task automatic test_register_extremes();
        drain_line();
        write_reg(CFG_STARTUP, TICK_MAX);
        write_reg(CFG_LONG_PRESS, TICK_MAX);
        write_reg(CFG_SHORT_GAP, TICK_MAX);
        write_reg(CFG_LONG_GAP, TICK_MAX);
        write_reg(CFG_HOLDOFF, TICK_MAX);
        send_toggled(1, 1'b1);
        send_toggled(30, 1'b0);
        send_toggled(24, 1'b1);
        // stuck in hold-off until released by the register
        drain_line();
        write_reg(CFG_HOLDOFF, '0);
        write_reg(CFG_LONG_PRESS, 24'd1);
        send_toggled(2, 1'b1);
        send_toggled(2, 1'b0);
        send_toggled(24, 1'b1);
        drain_line();
        write_reg(CFG_SHORT_GAP, '0);
        send_toggled(50, 1'b1);
        drain_line();
        write_reg(CFG_LONG_GAP, '0);
        while (m_phase != PH_IDLE)
            send_toggled(1, 1'b1);
    endtask

    task automatic test_unused_indexes();
        drain_line();
        for (int k = int'(CFG_HOLDOFF) + 1; k < (1 << CFG_IDX_W); k++)
            write_reg(k[CFG_IDX_W-1:0], CFG_W'($urandom));
        send_toggled(1, 1'b1);
        send_toggled(2, 1'b0);
        while (m_phase != PH_IDLE)
            send_toggled(1, 1'b1);
    endtask

    task automatic test_output_backpressure();
        gaps_on  = 1'b0;
        hold_req = 1'b1;
        repeat (40)
            send_tick(next_partner_clock(), next_button());
        drain_line();
    endtask

    task automatic test_random_traffic();
        for (int ph = 0; ph < 6; ph++) begin
            drain_line();
            write_reg(CFG_STARTUP, CFG_W'($urandom));
            write_reg(CFG_LONG_PRESS, CFG_W'(($urandom_range(0, 3) == 0)
                                             ? $urandom_range(0, 2)
                                             : $urandom_range(3, 40)));
            write_reg(CFG_SHORT_GAP, CFG_W'($urandom_range(0, 12)));
            write_reg(CFG_LONG_GAP, CFG_W'($urandom_range(0, 40)));
            write_reg(CFG_HOLDOFF, CFG_W'(($urandom_range(0, 3) == 0)
                                          ? 0 : $urandom_range(1, 50)));
            clk_half_max = $urandom_range(1, 4);
            clk_noise    = (ph == 3);
            gaps_on      = (ph % 3 != 1);
            repeat (150)
                send_tick(next_partner_clock(), next_button());
        end
    endtask

    // receiver: long hold on request, otherwise a rotating stall pattern
    always @(negedge i_clk) begin
        if (hold_req) begin
            hold_left = 48;
            hold_req  = 1'b0;
        end
        if (hold_left != 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            if (stall_pos == 0) begin
                case ($urandom_range(0, 3))
                    0:       stall_pat = '0;
                    1:       stall_pat = $urandom & $urandom;
                    2:       stall_pat = $urandom;
                    default: stall_pat = $urandom | $urandom;
                endcase
                // keep at least one free slot per window
                stall_pat[0] = 1'b0;
            end
            i_out_stall <= stall_pat[stall_pos];
            stall_pos   <= stall_pos + 5'd1;
        end
    end

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (line_q.size() == 0) begin
                $error("unexpected transfer: data_level=%0b sending=%0b command_byte=%02h",
                       o_data_level, o_sending, o_command_byte);
                err_cnt++;
            end else begin
                want = line_q.pop_front();
                if (o_data_level !== want.data_level) begin
                    $error("data_level: expected %0b, got %0b", want.data_level, o_data_level);
                    err_cnt++;
                end
                if (o_sending !== want.sending) begin
                    $error("sending: expected %0b, got %0b", want.sending, o_sending);
                    err_cnt++;
                end
                if (o_command_byte !== want.command_byte) begin
                    $error("command_byte: expected %02h, got %02h",
                           want.command_byte, o_command_byte);
                    err_cnt++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("button_command_serial_sender_top regression: fail");
            $finish;
        end
    end

    initial begin
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_power_on_init();
        test_short_press_sync();
        test_long_press_sequence();
        test_register_extremes();
        test_unused_indexes();
        test_output_backpressure();
        test_random_traffic();
        drain_line();
        repeat (8) @(posedge i_clk);
        if (err_cnt == 0)
            $display("button_command_serial_sender_top regression: pass");
        else
            $display("button_command_serial_sender_top regression: fail");
        $finish;
    end

endmodule

// ----- files.f -----
hdl/bcss_pkg.sv
hdl/button_command_serial_sender_top.sv
verif/tb.sv
